### hw/rtl/crf_pkg.sv
// Shared types, constants and codes for the control fragment reassembler.
// No dependencies; imported by control_fragment_reassembler.
`timescale 1ns / 1ps

package crf_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int BODY_BYTES   = 224;
    localparam int MESSAGE_MAX  = 1024;
    localparam int FRAGMENT_MAX = 8;
    localparam int FRAME_MAX    = 240;

    localparam logic [7:0] MAGIC0 = 8'h4E;
    localparam logic [7:0] MAGIC1 = 8'h46;
    localparam logic [7:0] MAGIC2 = 8'h01;
    localparam logic [7:0] KIND_MIN = 8'd1;
    localparam logic [7:0] KIND_MAX = 8'd4;

    localparam logic [10:0] CAPACITY_RESET = 11'd1024;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;

    localparam logic [1:0] FUNC_FRAME = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT    = 3'd4;
    localparam logic [2:0] ST_BUSY       = 3'd5;
    localparam logic [2:0] ST_CONFLICT   = 3'd6;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  frame_byte;
        logic        frame_last;
        logic [63:0] now_ms;
        logic [9:0]  read_address;
    } crf_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] message_length;
        logic [7:0]  read_data;
    } crf_out_t;

endpackage

### hw/rtl/crf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/control_fragment_reassembler.sv
// Control fragment reassembler top level: frame buffer, header checks and merge sequencer.
// Depends on crf_pkg and crf_ram.
`timescale 1ns / 1ps

// Frame bytes that are not last, clears and ignored codes leave the sequencer idle. The
// last byte of a frame runs the header checks (S_CHK1, S_CHK2), then copies or compares
// each body byte through the frame and message RAM ports (S_RD, S_WR), then hands the
// result beat to the output register (S_DONE). A read passes S_RDM, then S_DONE. Results
// wait in an output register; req_stall is high while the sequencer is busy.
// No clearing pass: unwritten message bytes are masked by the received bitmap.

module control_fragment_reassembler
    import crf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  crf_in_t     req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output crf_out_t    rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK1 = 3'd1;
    localparam logic [2:0] S_CHK2 = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_RDM  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]  state_reg;
    logic [10:0] cap_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  hdr_reg [HEADER_BYTES];
    logic [7:0]  count_reg;
    logic        ovf_reg;
    logic [7:0]  len_reg;
    logic        len_ovf_reg;
    logic [63:0] now_reg;
    logic        poison_reg;
    logic [63:0] open_token_reg;
    logic [2:0]  open_kind_reg;
    logic [10:0] open_total_reg;
    logic [3:0]  open_frag_reg;
    logic [63:0] start_reg;
    logic [7:0]  seen_reg;
    logic [9:0]  off_reg;
    logic [7:0]  size_reg;
    logic [10:0] total_reg;
    logic [3:0]  cnt_reg;
    logic [2:0]  fidx_reg;
    logic [2:0]  kind_reg;
    logic [63:0] token_reg;
    logic        cmp_reg;
    logic [7:0]  i_reg;
    logic        rd_ok_reg;
    crf_out_t    res_reg;
    logic        rsp_valid_reg;
    crf_out_t    rsp_reg;

    logic        accept;
    logic        frm_wr_en;
    logic [7:0]  frm_rd_addr;
    logic [7:0]  frm_rd_data;
    logic        msg_wr_en;
    logic [9:0]  msg_addr;
    logic [7:0]  msg_rd_data;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // header checks
    logic [15:0] total16;
    logic [7:0]  cnt8;
    logic [7:0]  idx8;
    logic [16:0] hi17;
    logic [16:0] lo17;
    logic [16:0] off17;
    logic [16:0] sz17;
    logic [16:0] szc17;
    logic [63:0] token;
    logic        bad_hdr;

    always_comb
    begin
        total16 = {hdr_reg[6], hdr_reg[7]};
        cnt8    = hdr_reg[5];
        idx8    = hdr_reg[4];
        hi17    = 17'(cnt8) * 17'(BODY_BYTES);
        lo17    = hi17 - 17'(BODY_BYTES);
        off17   = 17'(idx8) * 17'(BODY_BYTES);
        sz17    = 17'(total16) - off17;
        szc17   = (sz17 > 17'(BODY_BYTES)) ? 17'(BODY_BYTES) : sz17;
        token   = {hdr_reg[8], hdr_reg[9], hdr_reg[10], hdr_reg[11],
                   hdr_reg[12], hdr_reg[13], hdr_reg[14], hdr_reg[15]};
        bad_hdr = poison_reg || len_ovf_reg
               || len_reg <= 8'(HEADER_BYTES) || len_reg > 8'(FRAME_MAX)
               || hdr_reg[0] != MAGIC0 || hdr_reg[1] != MAGIC1 || hdr_reg[2] != MAGIC2
               || hdr_reg[3] < KIND_MIN || hdr_reg[3] > KIND_MAX
               || total16 == 16'd0 || total16 > 16'(MESSAGE_MAX)
               || cnt8 == 8'd0 || cnt8 > 8'(FRAGMENT_MAX)
               || 17'(total16) <= lo17 || 17'(total16) > hi17
               || idx8 >= cnt8
               || 17'(len_reg) != 17'(HEADER_BYTES) + szc17;
    end

    // exchange checks
    logic [63:0] age;
    logic        timed_out;
    logic [7:0]  frag_bit;
    logic [7:0]  seen_new;
    logic [7:0]  full_mask;

    always_comb
    begin
        age       = now_reg - start_reg;
        timed_out = (now_reg < start_reg) || (age > 64'(timeout_reg));
        frag_bit  = 8'd1 << fidx_reg;
        seen_new  = seen_reg | frag_bit;
        full_mask = 8'((9'd1 << cnt_reg) - 9'd1);
    end

    // read gating by fragment of the address
    logic [2:0] rd_frag;
    logic       rd_ok;

    always_comb
    begin
        rd_frag = 3'd0;
        for (int k = 1; k < FRAGMENT_MAX; k++)
        begin
            if (11'(req.read_address) >= 11'(k * BODY_BYTES))
            begin
                rd_frag = rd_frag + 3'd1;
            end
        end
        rd_ok = (11'(req.read_address) < open_total_reg) && seen_reg[rd_frag];
    end

    assign frm_wr_en   = (state_reg == S_IDLE) && accept && (req.func == FUNC_FRAME)
                      && (count_reg < 8'(FRAME_MAX));
    assign frm_rd_addr = 8'(HEADER_BYTES) + i_reg;
    assign msg_wr_en   = (state_reg == S_WR) && !cmp_reg;
    assign msg_addr    = (state_reg == S_IDLE) ? req.read_address : (off_reg + 10'(i_reg));

    crf_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_frame_ram (
        .clk     (clk),
        .wr_en   (frm_wr_en),
        .wr_addr (count_reg),
        .wr_data (req.frame_byte),
        .rd_addr (frm_rd_addr),
        .rd_data (frm_rd_data)
    );

    crf_ram #(.WIDTH(8), .DEPTH(MESSAGE_MAX)) u_msg_ram (
        .clk     (clk),
        .wr_en   (msg_wr_en),
        .wr_addr (msg_addr),
        .wr_data (frm_rd_data),
        .rd_addr (msg_addr),
        .rd_data (msg_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= CAPACITY_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            count_reg      <= 8'd0;
            ovf_reg        <= 1'b0;
            poison_reg     <= 1'b0;
            open_token_reg <= 64'd0;
            open_kind_reg  <= 3'd0;
            open_total_reg <= 11'd0;
            open_frag_reg  <= 4'd0;
            start_reg      <= 64'd0;
            seen_reg       <= 8'd0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CAPACITY: cap_reg     <= cfg_data[10:0];
                    CFG_TIMEOUT:  timeout_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (rsp_valid_reg && !rsp_stall && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.func == FUNC_FRAME)
                        begin
                            logic [7:0] cnt_after;
                            logic       ovf_after;
                            cnt_after = count_reg;
                            ovf_after = ovf_reg;
                            if (count_reg < 8'(FRAME_MAX))
                            begin
                                if (count_reg < 8'(HEADER_BYTES))
                                begin
                                    hdr_reg[count_reg[3:0]] <= req.frame_byte;
                                end
                                cnt_after = count_reg + 8'd1;
                            end
                            else
                            begin
                                ovf_after = 1'b1;
                            end
                            if (req.frame_last)
                            begin
                                len_reg     <= cnt_after;
                                len_ovf_reg <= ovf_after;
                                now_reg     <= req.now_ms;
                                count_reg   <= 8'd0;
                                ovf_reg     <= 1'b0;
                                state_reg   <= S_CHK1;
                            end
                            else
                            begin
                                count_reg <= cnt_after;
                                ovf_reg   <= ovf_after;
                            end
                        end
                        else if (req.func == FUNC_READ)
                        begin
                            rd_ok_reg <= rd_ok;
                            state_reg <= S_RDM;
                        end
                        else if (req.func == FUNC_CLEAR)
                        begin
                            count_reg      <= 8'd0;
                            ovf_reg        <= 1'b0;
                            poison_reg     <= 1'b0;
                            open_token_reg <= 64'd0;
                            open_kind_reg  <= 3'd0;
                            open_total_reg <= 11'd0;
                            open_frag_reg  <= 4'd0;
                            start_reg      <= 64'd0;
                            seen_reg       <= 8'd0;
                        end
                    end
                end
                S_CHK1:
                begin
                    res_reg.message_length <= 11'd0;
                    res_reg.read_data      <= 8'd0;
                    off_reg   <= off17[9:0];
                    size_reg  <= szc17[7:0];
                    total_reg <= total16[10:0];
                    cnt_reg   <= cnt8[3:0];
                    fidx_reg  <= idx8[2:0];
                    kind_reg  <= hdr_reg[3][2:0];
                    token_reg <= token;
                    if (bad_hdr)
                    begin
                        res_reg.status <= ST_INVALID;
                        state_reg      <= S_DONE;
                    end
                    else if (16'(cap_reg) < total16)
                    begin
                        res_reg.status <= ST_TOO_LARGE;
                        state_reg      <= S_DONE;
                    end
                    else if (token == 64'd0)
                    begin
                        res_reg.status <= ST_INVALID;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CHK2;
                    end
                end
                S_CHK2:
                begin
                    i_reg <= 8'd0;
                    if (open_token_reg != 64'd0 && timed_out)
                    begin
                        poison_reg     <= 1'b0;
                        open_token_reg <= 64'd0;
                        open_kind_reg  <= 3'd0;
                        open_total_reg <= 11'd0;
                        open_frag_reg  <= 4'd0;
                        start_reg      <= 64'd0;
                        seen_reg       <= 8'd0;
                        res_reg.status <= ST_TIMEOUT;
                        state_reg      <= S_DONE;
                    end
                    else if (open_token_reg != 64'd0
                          && (open_token_reg != token_reg || open_kind_reg != kind_reg))
                    begin
                        res_reg.status <= ST_BUSY;
                        state_reg      <= S_DONE;
                    end
                    else if (open_token_reg != 64'd0
                          && (open_total_reg != total_reg || open_frag_reg != cnt_reg))
                    begin
                        poison_reg     <= 1'b1;
                        res_reg.status <= ST_CONFLICT;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        if (open_token_reg == 64'd0)
                        begin
                            open_token_reg <= token_reg;
                            open_kind_reg  <= kind_reg;
                            open_total_reg <= total_reg;
                            open_frag_reg  <= cnt_reg;
                            start_reg      <= now_reg;
                        end
                        cmp_reg   <= (seen_reg & frag_bit) != 8'd0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (cmp_reg && frm_rd_data != msg_rd_data)
                    begin
                        poison_reg     <= 1'b1;
                        res_reg.status <= ST_CONFLICT;
                        state_reg      <= S_DONE;
                    end
                    else if (i_reg + 8'd1 == size_reg)
                    begin
                        seen_reg <= seen_new;
                        if (seen_new == full_mask)
                        begin
                            res_reg.status         <= ST_OK;
                            res_reg.message_length <= total_reg;
                        end
                        else
                        begin
                            res_reg.status <= ST_INCOMPLETE;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 8'd1;
                        state_reg <= S_RD;
                    end
                end
                S_RDM:
                begin
                    res_reg.status         <= ST_OK;
                    res_reg.message_length <= 11'd0;
                    res_reg.read_data      <= rd_ok_reg ? msg_rd_data : 8'd0;
                    state_reg              <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.message_length == 11'd0)
        else $error("message_length set on a non-ok beat");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |-> i_reg < size_reg)
        else $error("body index past fragment size");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 8'(FRAME_MAX))
        else $error("frame counter past buffer");
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the hand-off state");
`endif

endmodule
